// File: rtl/sample_mean_and_std_dev_unit_defines.svh
`ifndef SAMPLE_MEAN_AND_STD_DEV_UNIT_DEFINES_SVH
`define SAMPLE_MEAN_AND_STD_DEV_UNIT_DEFINES_SVH

// Check that holds in the same cycle as its trigger.
`define SMS_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Check that holds in the cycle after its trigger.
`define SMS_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/sms_pkg.sv
package sms_pkg;

    localparam int unsigned SAMPLE_W          = 16;
    localparam int unsigned CNT_W             = 17;
    localparam int unsigned SUM_W             = 33;
    localparam int unsigned SSQ_W             = 47;
    localparam int unsigned SQ_W              = 32;
    localparam int unsigned MAG_W             = 32;
    localparam int unsigned WIDE_W            = 64;
    localparam int unsigned DEN_W             = 32;
    localparam int unsigned RESULT_W          = 16;
    localparam int unsigned ROOT_STEPS        = 32;
    localparam int unsigned ROOT_K_W          = $clog2(ROOT_STEPS);
    localparam int unsigned MAX_COUNT_DEFAULT = 65536;
    localparam int unsigned FIFO_DEPTH        = 2;
    localparam int unsigned FIFO_PTR_W        = $clog2(FIFO_DEPTH);
    localparam int unsigned FIFO_LVL_W        = $clog2(FIFO_DEPTH + 1);

    localparam int unsigned IN_DATA_W   = 16;
    localparam int unsigned OUT_FIELD_W = RESULT_W + RESULT_W + CNT_W;
    localparam int unsigned OUT_DATA_W  = ((OUT_FIELD_W + 7) / 8) * 8;
    localparam int unsigned OUT_PAD_W   = OUT_DATA_W - OUT_FIELD_W;
    localparam int unsigned OUT_USER_W  = 1;

    // Highest even power of two in the root search.
    localparam logic [WIDE_W-1:0] ROOT_TOP = WIDE_W'(1) << (WIDE_W - 2);

    // One finished set handed from the accumulator to the finishing unit.
    typedef struct packed {
        logic [CNT_W-1:0]        cnt;
        logic signed [SUM_W-1:0] sum;
        logic [SSQ_W-1:0]        sum_sq;
        logic                    ovf;
    } sms_set_t;

    typedef struct packed {
        logic empty;
        logic full;
    } sms_fifo_stat_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_MUL_SQ,
        ST_MUL_LO,
        ST_MUL_HI,
        ST_MUL_DEN,
        ST_SUB,
        ST_DIV_MEAN,
        ST_DIV_STD,
        ST_ROOT,
        ST_FINISH
    } sms_state_t;

endpackage

// File: rtl/sms_front.sv
module sms_front #(
    parameter int unsigned MAX_COUNT = sms_pkg::MAX_COUNT_DEFAULT
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic signed [sms_pkg::SAMPLE_W-1:0] sample,
    input  logic                                last_sample,
    input  sms_pkg::sms_fifo_stat_t             fifo_stat,
    output logic                                push,
    output sms_pkg::sms_set_t                   push_data
);
    import sms_pkg::*;

    logic [CNT_W-1:0]        cnt_reg, cnt_next, upd_cnt;
    logic signed [SUM_W-1:0] sum_reg, sum_next, upd_sum;
    logic [SSQ_W-1:0]        ssq_reg, ssq_next, upd_ssq;
    logic                    ovf_reg, ovf_next, upd_ovf;
    logic signed [SQ_W-1:0]  sq;
    logic                    full_set;
    logic                    take;

    always_comb
    begin
        in_ready = !fifo_stat.full;
        take     = in_valid && in_ready;
        sq       = sample * sample;
        full_set = cnt_reg >= CNT_W'(MAX_COUNT);

        // Drop samples past a full set, but remember that they came.
        upd_cnt = full_set ? cnt_reg : cnt_reg + CNT_W'(1);
        upd_sum = full_set ? sum_reg : sum_reg + SUM_W'(sample);
        upd_ssq = full_set ? ssq_reg : ssq_reg + SSQ_W'($unsigned(sq));
        upd_ovf = ovf_reg | full_set;

        push             = take && last_sample;
        push_data.cnt    = upd_cnt;
        push_data.sum    = upd_sum;
        push_data.sum_sq = upd_ssq;
        push_data.ovf    = upd_ovf;

        cnt_next = cnt_reg;
        sum_next = sum_reg;
        ssq_next = ssq_reg;
        ovf_next = ovf_reg;
        if (take)
        begin
            if (last_sample)
            begin
                cnt_next = '0;
                sum_next = '0;
                ssq_next = '0;
                ovf_next = 1'b0;
            end
            else
            begin
                cnt_next = upd_cnt;
                sum_next = upd_sum;
                ssq_next = upd_ssq;
                ovf_next = upd_ovf;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
            sum_reg <= '0;
            ssq_reg <= '0;
            ovf_reg <= 1'b0;
        end
        else
        begin
            cnt_reg <= cnt_next;
            sum_reg <= sum_next;
            ssq_reg <= ssq_next;
            ovf_reg <= ovf_next;
        end
    end

endmodule

// File: rtl/sms_fifo.sv
module sms_fifo (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    push,
    input  sms_pkg::sms_set_t       push_data,
    input  logic                    pop,
    output sms_pkg::sms_set_t       pop_data,
    output sms_pkg::sms_fifo_stat_t stat
);
    import sms_pkg::*;

    sms_set_t              entry_reg [FIFO_DEPTH];
    logic [FIFO_PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [FIFO_PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [FIFO_LVL_W-1:0] lvl_reg, lvl_next;
    logic                  do_push, do_pop;

    always_comb
    begin
        stat.full  = lvl_reg == FIFO_LVL_W'(FIFO_DEPTH);
        stat.empty = lvl_reg == '0;
        do_push    = push && !stat.full;
        do_pop     = pop && !stat.empty;
        pop_data   = entry_reg[rd_ptr_reg];

        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        lvl_next    = lvl_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == FIFO_PTR_W'(FIFO_DEPTH - 1)) ? '0
                                                                       : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == FIFO_PTR_W'(FIFO_DEPTH - 1)) ? '0
                                                                       : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            lvl_next = lvl_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            lvl_next = lvl_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            lvl_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            lvl_reg    <= lvl_next;
        end
    end

endmodule

// File: rtl/sms_div.sv
module sms_div (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    input  logic [sms_pkg::WIDE_W-1:0]  dividend,
    input  logic [sms_pkg::DEN_W-1:0]   divisor,
    output logic                        done,
    output logic [sms_pkg::WIDE_W-1:0]  quotient
);
    import sms_pkg::*;

    localparam int unsigned STEP_W = $clog2(WIDE_W);

    logic                busy_reg, busy_next;
    logic                done_reg, done_next;
    logic [STEP_W-1:0]   step_reg, step_next;
    logic [WIDE_W-1:0]   quo_reg, quo_next;
    logic [DEN_W-1:0]    rem_reg, rem_next;
    logic [DEN_W-1:0]    dvs_reg, dvs_next;
    logic [DEN_W:0]      rem_sh;
    logic [DEN_W:0]      rem_diff;
    logic                fits;

    // Restoring division, one quotient bit per cycle.
    always_comb
    begin
        rem_sh   = {rem_reg, quo_reg[WIDE_W-1]};
        rem_diff = rem_sh - {1'b0, dvs_reg};
        fits     = rem_sh >= {1'b0, dvs_reg};

        busy_next = busy_reg;
        done_next = 1'b0;
        step_next = step_reg;
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        dvs_next  = dvs_reg;
        if (start)
        begin
            busy_next = 1'b1;
            step_next = '0;
            quo_next  = dividend;
            rem_next  = '0;
            dvs_next  = divisor;
        end
        else if (busy_reg)
        begin
            quo_next  = {quo_reg[WIDE_W-2:0], fits};
            rem_next  = fits ? rem_diff[DEN_W-1:0] : rem_sh[DEN_W-1:0];
            step_next = step_reg + 1'b1;
            if (step_reg == STEP_W'(WIDE_W - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        dvs_reg <= dvs_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            step_reg <= step_next;
        end
    end

endmodule

// File: rtl/sms_back.sv
module sms_back (
    input  logic                                clk,
    input  logic                                rst_n,
    input  sms_pkg::sms_fifo_stat_t             fifo_stat,
    input  sms_pkg::sms_set_t                   pop_data,
    output logic                                pop,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic signed [sms_pkg::RESULT_W-1:0] mean_value,
    output logic [sms_pkg::RESULT_W-1:0]        std_dev,
    output logic [sms_pkg::CNT_W-1:0]           sample_count,
    output logic                                overflow
);
    import sms_pkg::*;

    sms_state_t            state_reg, state_next;
    logic [CNT_W-1:0]      n_reg, n_next;
    logic [MAG_W-1:0]      mag_reg, mag_next;
    logic                  neg_reg, neg_next;
    logic [SSQ_W-1:0]      s2_reg, s2_next;
    logic                  ovf_reg, ovf_next;
    logic [WIDE_W-1:0]     sq_reg, sq_next;
    logic [WIDE_W-1:0]     ns2_reg, ns2_next;
    logic [DEN_W-1:0]      hi_reg, hi_next;
    logic [DEN_W-1:0]      den_reg, den_next;
    logic [WIDE_W-1:0]     num_reg, num_next;
    logic [RESULT_W-1:0]   mean_reg, mean_next;
    logic [RESULT_W-1:0]   sd_reg, sd_next;
    logic [WIDE_W-1:0]     rv_reg, rv_next;
    logic [WIDE_W-1:0]     rres_reg, rres_next;
    logic [ROOT_K_W-1:0]   rk_reg, rk_next;
    logic                  ov_reg, ov_next;
    logic [RESULT_W-1:0]   om_reg, om_next;
    logic [RESULT_W-1:0]   osd_reg, osd_next;
    logic [CNT_W-1:0]      ocnt_reg, ocnt_next;
    logic                  oovf_reg, oovf_next;

    logic [MAG_W-1:0]      mul_a, mul_b;
    logic [WIDE_W-1:0]     mul_p;
    logic                  div_start;
    logic [WIDE_W-1:0]     div_dividend;
    logic [DEN_W-1:0]      div_divisor;
    logic                  div_done;
    logic [WIDE_W-1:0]     div_q;
    logic [WIDE_W-1:0]     mean_q;
    logic [WIDE_W-1:0]     rbit;
    logic [WIDE_W-1:0]     rtrial;
    logic [WIDE_W-1:0]     rres_upd;
    logic signed [SUM_W-1:0] abs_sum;

    sms_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .done     (div_done),
        .quotient (div_q)
    );

    assign mul_p = mul_a * mul_b;

    always_comb
    begin
        state_next = state_reg;
        n_next     = n_reg;
        mag_next   = mag_reg;
        neg_next   = neg_reg;
        s2_next    = s2_reg;
        ovf_next   = ovf_reg;
        sq_next    = sq_reg;
        ns2_next   = ns2_reg;
        hi_next    = hi_reg;
        den_next   = den_reg;
        num_next   = num_reg;
        mean_next  = mean_reg;
        sd_next    = sd_reg;
        rv_next    = rv_reg;
        rres_next  = rres_reg;
        rk_next    = rk_reg;
        ov_next    = ov_reg && !out_ready;
        om_next    = om_reg;
        osd_next   = osd_reg;
        ocnt_next  = ocnt_reg;
        oovf_next  = oovf_reg;

        pop          = 1'b0;
        mul_a        = mag_reg;
        mul_b        = mag_reg;
        div_start    = 1'b0;
        div_dividend = WIDE_W'(mag_reg);
        div_divisor  = DEN_W'(n_reg);
        abs_sum      = pop_data.sum[SUM_W-1] ? -pop_data.sum : pop_data.sum;
        mean_q       = neg_reg ? -div_q : div_q;
        rbit         = ROOT_TOP >> {rk_reg, 1'b0};
        rtrial       = rres_reg + rbit;
        rres_upd     = (rv_reg >= rtrial) ? (rres_reg >> 1) + rbit : rres_reg >> 1;

        case (state_reg)
            ST_IDLE:
            begin
                if (!fifo_stat.empty)
                begin
                    pop        = 1'b1;
                    n_next     = pop_data.cnt;
                    s2_next    = pop_data.sum_sq;
                    ovf_next   = pop_data.ovf;
                    neg_next   = pop_data.sum[SUM_W-1];
                    mag_next   = MAG_W'(abs_sum);
                    state_next = ST_MUL_SQ;
                end
            end
            ST_MUL_SQ:
            begin
                sq_next    = mul_p;
                state_next = ST_MUL_LO;
            end
            ST_MUL_LO:
            begin
                mul_a      = MAG_W'(n_reg);
                mul_b      = s2_reg[MAG_W-1:0];
                ns2_next   = mul_p;
                state_next = ST_MUL_HI;
            end
            ST_MUL_HI:
            begin
                mul_a      = MAG_W'(n_reg);
                mul_b      = MAG_W'(s2_reg[SSQ_W-1:MAG_W]);
                hi_next    = mul_p[DEN_W-1:0];
                state_next = ST_MUL_DEN;
            end
            ST_MUL_DEN:
            begin
                mul_a      = MAG_W'(n_reg);
                mul_b      = MAG_W'(n_reg - CNT_W'(1));
                den_next   = mul_p[DEN_W-1:0];
                ns2_next   = ns2_reg + {hi_reg, {(WIDE_W - DEN_W){1'b0}}};
                state_next = ST_SUB;
            end
            ST_SUB:
            begin
                // Clamp the variance numerator at zero.
                num_next   = (ns2_reg >= sq_reg) ? ns2_reg - sq_reg : '0;
                div_start  = 1'b1;
                state_next = ST_DIV_MEAN;
            end
            ST_DIV_MEAN:
            begin
                if (div_done)
                begin
                    mean_next = mean_q[RESULT_W-1:0];
                    if (n_reg > CNT_W'(1))
                    begin
                        div_start    = 1'b1;
                        div_dividend = num_reg;
                        div_divisor  = den_reg;
                        state_next   = ST_DIV_STD;
                    end
                    else
                    begin
                        sd_next    = '0;
                        state_next = ST_FINISH;
                    end
                end
            end
            ST_DIV_STD:
            begin
                if (div_done)
                begin
                    rv_next    = div_q;
                    rres_next  = '0;
                    rk_next    = '0;
                    state_next = ST_ROOT;
                end
            end
            ST_ROOT:
            begin
                if (rv_reg >= rtrial)
                begin
                    rv_next = rv_reg - rtrial;
                end
                rres_next = rres_upd;
                rk_next   = rk_reg + 1'b1;
                if (rk_reg == ROOT_K_W'(ROOT_STEPS - 1))
                begin
                    sd_next    = rres_upd[RESULT_W-1:0];
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH:
            begin
                if (!ov_reg || out_ready)
                begin
                    ov_next    = 1'b1;
                    om_next    = mean_reg;
                    osd_next   = sd_reg;
                    ocnt_next  = n_reg;
                    oovf_next  = ovf_reg;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign out_valid    = ov_reg;
    assign mean_value   = om_reg;
    assign std_dev      = osd_reg;
    assign sample_count = ocnt_reg;
    assign overflow     = oovf_reg;

    always_ff @(posedge clk)
    begin
        n_reg    <= n_next;
        mag_reg  <= mag_next;
        neg_reg  <= neg_next;
        s2_reg   <= s2_next;
        ovf_reg  <= ovf_next;
        sq_reg   <= sq_next;
        ns2_reg  <= ns2_next;
        hi_reg   <= hi_next;
        den_reg  <= den_next;
        num_reg  <= num_next;
        mean_reg <= mean_next;
        sd_reg   <= sd_next;
        rv_reg   <= rv_next;
        rres_reg <= rres_next;
        rk_reg   <= rk_next;
        om_reg   <= om_next;
        osd_reg  <= osd_next;
        ocnt_reg <= ocnt_next;
        oovf_reg <= oovf_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            ov_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            ov_reg    <= ov_next;
        end
    end

endmodule

// File: rtl/sample_mean_and_std_dev_unit.sv
// Sample mean and sample standard deviation over sets of signed Q8.8 samples.
// Each input word carries one sample in tdata and marks the last sample of a
// set with tlast. Samples are taken one per cycle; the accumulator keeps a
// count, a sum and a sum of squares, and on the last sample hands the set to a
// two-entry queue and starts the next set at once. A finishing unit takes sets
// from the queue and produces one output word per set: the mean (sum over
// count, truncated toward zero) and the standard deviation with an n-1
// divisor, floor(sqrt((n*S2 - S1^2) / (n*(n-1)))), which is 0 for a set of one
// sample. Finishing a set uses a single 32x32 multiplier four times, then a
// shared radix-2 divider of 64 steps twice, then a 32-step integer square
// root; a one-sample set skips the second run and the root. Input stalls only
// while two finished sets wait in the queue. A set longer than MAX_COUNT keeps
// its first MAX_COUNT samples, reports that count and raises the overflow flag.
`include "sample_mean_and_std_dev_unit_defines.svh"

module sample_mean_and_std_dev_unit #(
    parameter int unsigned MAX_COUNT = sms_pkg::MAX_COUNT_DEFAULT
) (
    input  logic                               clk,
    input  logic                               rst_n,
    // sample stream
    input  logic                               s_axis_tvalid,
    output logic                               s_axis_tready,
    input  logic [sms_pkg::IN_DATA_W-1:0]      s_axis_tdata,  // [15:0] sample
    input  logic                               s_axis_tlast,  // last_sample
    // result stream
    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    output logic [sms_pkg::OUT_DATA_W-1:0]     m_axis_tdata,  // [15:0] mean_value,
                                                              // [31:16] std_dev,
                                                              // [48:32] sample_count,
                                                              // [55:49] zero
    output logic [sms_pkg::OUT_USER_W-1:0]     m_axis_tuser   // [0] overflow
);
    import sms_pkg::*;

    logic                        push;
    sms_set_t                    push_data;
    logic                        pop;
    sms_set_t                    pop_data;
    sms_fifo_stat_t              fifo_stat;
    logic signed [RESULT_W-1:0]  out_mean;
    logic [RESULT_W-1:0]         out_sd;
    logic [CNT_W-1:0]            out_cnt;
    logic                        out_ovf;

    // Front: accumulate samples, close a set on tlast.
    sms_front #(
        .MAX_COUNT (MAX_COUNT)
    ) u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (s_axis_tvalid),
        .in_ready    (s_axis_tready),
        .sample      ($signed(s_axis_tdata[SAMPLE_W-1:0])),
        .last_sample (s_axis_tlast),
        .fifo_stat   (fifo_stat),
        .push        (push),
        .push_data   (push_data)
    );

    // Queue of closed sets between the two sides.
    sms_fifo u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .pop       (pop),
        .pop_data  (pop_data),
        .stat      (fifo_stat)
    );

    // Back: mean, variance, root; holds the result word until taken.
    sms_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .fifo_stat    (fifo_stat),
        .pop_data     (pop_data),
        .pop          (pop),
        .out_valid    (m_axis_tvalid),
        .out_ready    (m_axis_tready),
        .mean_value   (out_mean),
        .std_dev      (out_sd),
        .sample_count (out_cnt),
        .overflow     (out_ovf)
    );

    // Pack fields from the lowest bit up.
    assign m_axis_tdata = {{OUT_PAD_W{1'b0}}, out_cnt, out_sd, out_mean};
    assign m_axis_tuser = OUT_USER_W'(out_ovf);

    `SMS_ASSERT_NOW(a_cnt_range, m_axis_tvalid,
        (out_cnt != '0) && (out_cnt <= CNT_W'(MAX_COUNT)),
        "result count outside 1..MAX_COUNT")
    `SMS_ASSERT_NOW(a_ovf_full, m_axis_tvalid && out_ovf,
        out_cnt == CNT_W'(MAX_COUNT),
        "overflow flagged on a set that is not full")
    `SMS_ASSERT_NOW(a_single_zero, m_axis_tvalid && (out_cnt == CNT_W'(1)),
        out_sd == '0,
        "single-sample set with nonzero deviation")
    `SMS_ASSERT_NEXT(a_set_queued, s_axis_tvalid && s_axis_tready && s_axis_tlast,
        !fifo_stat.empty,
        "closed set not present in queue")

endmodule
